// ===== hdl/fbrx_pkg.sv =====
package fbrx_pkg;

  // header and acknowledgement bytes
  localparam logic [7:0] HDR_START    = 8'h1E;
  localparam logic [7:0] HDR_TYPE     = 8'h0C;
  localparam logic [7:0] CMD_ACK      = 8'h7F;
  localparam logic [7:0] ACK_LEN      = 8'h02;
  localparam logic [2:0] SEQ_MASK     = 3'h7;

  // reset values of the frame state
  localparam logic [7:0] CMD_RESET    = 8'hD2;
  localparam logic [2:0] SEQ_RESET    = 3'd2;

  // acknowledgement slots
  localparam logic [3:0]  SLOT_LAST   = 4'd9;

  // result kinds
  localparam logic KIND_TX_BYTE       = 1'b0;
  localparam logic KIND_PARTNER_ACK   = 1'b1;

  // acknowledgement byte for a slot
  function automatic logic [7:0] ack_byte(input logic [3:0] slot,
                                          input logic [7:0] cmd,
                                          input logic [2:0] seq);
    logic [7:0] b;
    b = 8'h00;
    unique case (slot)
      4'd0: b = HDR_START;
      4'd1: b = 8'h00;
      4'd2: b = HDR_TYPE;
      4'd3: b = CMD_ACK;
      4'd4: b = 8'h00;
      4'd5: b = ACK_LEN;
      4'd6: b = cmd;
      4'd7: b = {5'd0, seq};
      4'd8: b = HDR_START ^ HDR_TYPE ^ cmd;
      4'd9: b = CMD_ACK ^ ACK_LEN ^ {5'd0, seq};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/fbus_frame_receive_ack_unit.sv =====
// channel  | ports                 | payload
// ---------+-----------------------+----------------------------------------
// in       | s_tvalid/s_tready     | s_tdata[7:0] rx_byte
// out      | m_tvalid/m_tready     | m_tdata[7:0] tx_byte, [10:8] ack_sequence
//          |                       | m_tuser kind, m_tlast last
//
// a request goes into an input register, then one pass of header match and
// body counting updates the frame state; accepts a byte per cycle unless held.
// a byte that closes a frame loads the result register, which plays out ten
// acknowledgement bytes (one per cycle while ready) or one partner-ack event.
// such a byte waits in the input register only while the previous burst is
// still being drained; stalls on the out side never drop or repeat results.
// rst is synchronous and clears all control state.
module fbus_frame_receive_ack_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] tx_byte, [10:8] ack_sequence, rest zero
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast
);
  import fbrx_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // frame state
  logic [7:0] hist [6];
  logic       receiving;
  logic [8:0] frame_size;
  logic [8:0] byte_count;
  logic [7:0] frame_command;
  logic [2:0] sequence_held;
  logic [7:0] seq_pos;
  logic       seq_pos_valid;

  // result register
  logic       busy;
  logic       out_kind;
  logic [7:0] out_cmd;
  logic [2:0] out_seq;
  logic [3:0] slot;

  logic       ends_frame;
  logic       header_hit;
  logic       out_last;
  logic       can_load;
  logic       advance;
  logic [2:0] sequence_next;

  // frame end and header match on the registered byte
  assign ends_frame = receiving && (byte_count == frame_size);
  assign header_hit = (hist[0] == 8'h00) && (hist[2] == 8'h00) &&
                      (hist[3] == HDR_TYPE) && (hist[4] == HDR_START);

  assign sequence_next = (receiving && seq_pos_valid && (byte_count == {1'b0, seq_pos}))
                         ? (in_byte[2:0] & SEQ_MASK) : sequence_held;

  // output side
  assign out_last = (out_kind == KIND_PARTNER_ACK) || (slot == SLOT_LAST);
  assign can_load = !busy || (m_tready && out_last);
  assign advance  = in_valid && (!ends_frame || can_load);
  assign s_tready = !in_valid || advance;

  assign m_tvalid = busy;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'd0, out_seq,
                     (out_kind == KIND_PARTNER_ACK) ? 8'h00 : ack_byte(slot, out_cmd, out_seq)};

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // header hunt and body count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) hist[i] <= 8'h00;
      receiving     <= 1'b0;
      frame_size    <= 9'd0;
      byte_count    <= 9'd0;
      frame_command <= CMD_RESET;
      sequence_held <= SEQ_RESET;
      seq_pos       <= 8'd0;
      seq_pos_valid <= 1'b0;
    end else if (advance) begin
      if (!receiving) begin
        for (int i = 5; i > 0; i--) hist[i] <= hist[i-1];
        hist[0] <= in_byte;
        if (header_hit) begin
          frame_command <= hist[1];
          frame_size    <= in_byte[0] ? ({1'b0, in_byte} + 9'd2) : ({1'b0, in_byte} + 9'd1);
          seq_pos_valid <= (in_byte != 8'h00);
          seq_pos       <= (in_byte != 8'h00) ? (in_byte - 8'd1) : 8'd0;
          byte_count    <= 9'd0;
          receiving     <= 1'b1;
        end
      end else begin
        sequence_held <= sequence_next;
        byte_count    <= byte_count + 9'd1;
        if (ends_frame) begin
          receiving <= 1'b0;
        end
      end
    end
  end

  // result register and burst slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= 4'd0;
    end else if (advance && ends_frame) begin
      busy <= 1'b1;
      slot <= 4'd0;
    end else if (busy && m_tready) begin
      if (out_last) begin
        busy <= 1'b0;
      end else begin
        slot <= slot + 4'd1;
      end
    end
    if (advance && ends_frame) begin
      out_kind <= (frame_command == CMD_ACK) ? KIND_PARTNER_ACK : KIND_TX_BYTE;
      out_cmd  <= frame_command;
      out_seq  <= sequence_next;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import fbrx_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 50;
  localparam int RANDOM_BYTES = 40;
  localparam int QUIET_BYTES  = 30;

  // one result of the block as it leaves on the out side
  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [2:0] seq;
    logic       last;
  } ack_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // [7:0] tx_byte, [10:8] ack_sequence, rest zero
  logic        m_tuser;   // [0] kind
  logic        m_tlast;

  // both sides idle at random while this is set
  logic idle_en = 1'b1;

  // frame tracker state, mirrors the block
  logic [7:0] hist [6] = '{default: 8'h00};
  logic       in_frame = 1'b0;
  logic [8:0] body_final = 9'd0;
  logic [8:0] body_index = 9'd0;
  logic [7:0] frame_cmd = CMD_RESET;
  logic [2:0] frame_seq = SEQ_RESET;
  logic [8:0] seq_index = 9'd0;
  logic       seq_index_ok = 1'b0;

  ack_result_t pending_acks [$];

  int errors = 0;
  int bytes_sent = 0;
  int frames_closed = 0;
  int acks_seen = 0;
  int partner_acks_seen = 0;

  fbus_frame_receive_ack_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hunt for the header, count the body, queue the reply of a closed frame
  task automatic absorb_rx_byte(input logic [7:0] b);
    logic [8:0]  len9;
    logic [7:0]  reply [10];
    ack_result_t r;
    if (!in_frame) begin
      for (int i = 5; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = b;
      if (hist[1] == 8'h00 && hist[3] == 8'h00 && hist[4] == HDR_TYPE &&
          hist[5] == HDR_START) begin
        len9 = {1'b0, hist[0]};
        frame_cmd = hist[2];
        body_final = len9[0] ? len9 + 9'd2 : len9 + 9'd1;
        seq_index_ok = (len9 != 9'd0);
        seq_index = seq_index_ok ? len9 - 9'd1 : 9'd0;
        body_index = 9'd0;
        in_frame = 1'b1;
      end
    end else begin
      if (seq_index_ok && body_index == seq_index) frame_seq = b[2:0];
      if (body_index != body_final) begin
        body_index = body_index + 9'd1;
      end else begin
        body_index = body_index + 9'd1;
        in_frame = 1'b0;
        frames_closed++;
        if (frame_cmd == CMD_ACK) begin
          r = '{kind: KIND_PARTNER_ACK, tx_byte: 8'h00, seq: frame_seq, last: 1'b1};
          pending_acks.push_back(r);
        end else begin
          reply[0] = HDR_START;
          reply[1] = 8'h00;
          reply[2] = HDR_TYPE;
          reply[3] = CMD_ACK;
          reply[4] = 8'h00;
          reply[5] = ACK_LEN;
          reply[6] = frame_cmd;
          reply[7] = {5'd0, frame_seq};
          reply[8] = reply[0] ^ reply[2] ^ reply[4] ^ reply[6];
          reply[9] = reply[1] ^ reply[3] ^ reply[5] ^ reply[7];
          for (int i = 0; i < 10; i++) begin
            r = '{kind: KIND_TX_BYTE, tx_byte: reply[i], seq: frame_seq,
                  last: (i == 9)};
            pending_acks.push_back(r);
          end
        end
      end
    end
  endtask

  function automatic void note_mismatch(input string what, input int exp_v,
                                        input int got_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t tb: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v,
               got_v);
  endfunction

  // request tracking on the in side, result check on the out side
  always @(posedge clk) begin
    ack_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) absorb_rx_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (pending_acks.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t tb: unexpected result, expected none, got tdata 0x%0h tuser %0b",
                     $time, m_tdata, m_tuser);
        end else begin
          want = pending_acks.pop_front();
          if (m_tuser !== want.kind) note_mismatch("kind", want.kind, m_tuser);
          if (m_tdata[7:0] !== want.tx_byte)
            note_mismatch("tx_byte", want.tx_byte, m_tdata[7:0]);
          if (m_tdata[10:8] !== want.seq) note_mismatch("ack_sequence", want.seq, m_tdata[10:8]);
          if (m_tdata[15:11] !== 5'd0) note_mismatch("tdata pad", 0, m_tdata[15:11]);
          if (m_tlast !== want.last) note_mismatch("last", want.last, m_tlast);
          if (want.last && want.kind == KIND_TX_BYTE) acks_seen++;
          if (want.kind == KIND_PARTNER_ACK) partner_acks_seen++;
        end
      end
    end
  end

  // out side backpressure
  always @(posedge clk) begin
    m_tready <= !idle_en || ($urandom_range(99) >= 16);
  end

  // one request on the in side, with an optional gap before it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (idle_en)
      while ($urandom_range(99) < 16) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // hold the in side until every queued result is out, then let it settle
  task automatic wait_for_acks();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_header(input logic [7:0] cmd, input logic [7:0] len);
    send_byte(HDR_START);
    send_byte(HDR_TYPE);
    send_byte(8'h00);
    send_byte(cmd);
    send_byte(8'h00);
    send_byte(len);
  endtask

  // body bytes up to and including the one that closes the frame
  function automatic int body_length(input logic [7:0] len);
    return (len[0] ? int'(len) + 2 : int'(len) + 1) + 1;
  endfunction

  task automatic send_random_frame(input int max_len);
    logic [7:0] cmd;
    logic [7:0] len;
    cmd = ($urandom_range(3) == 0) ? CMD_ACK : 8'($urandom_range(255));
    len = 8'($urandom_range(max_len));
    send_header(cmd, len);
    repeat (body_length(len)) send_byte(8'($urandom_range(255)));
  endtask

  // header with one wrong byte, or cut short
  task automatic send_broken_header();
    logic [7:0] hb [6];
    int cut;
    int spot;
    hb = '{HDR_START, HDR_TYPE, 8'h00, 8'($urandom_range(255)), 8'h00,
           8'($urandom_range(255))};
    cut = 6;
    if ($urandom_range(1) == 0) begin
      cut = $urandom_range(1, 5);
    end else begin
      spot = $urandom_range(3);
      if (spot == 3) spot = 4;
      hb[spot] = hb[spot] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < cut; i++) send_byte(hb[i]);
  endtask

  // zero length, odd length with partner ack, header lookalike in the body
  task automatic test_directed_frames();
    send_header(8'h00, 8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_header(CMD_ACK, 8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_header(8'hFF, 8'h02);
    send_byte(HDR_START);
    send_byte(HDR_TYPE);
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  // length 255 needs the ninth bit of the body count
  task automatic test_size_wrap();
    send_header(8'h5A, 8'hFF);
    repeat (body_length(8'hFF)) send_byte(8'($urandom_range(255)));
    wait_for_acks();
  endtask

  // back-to-back frames with neither side idling
  task automatic test_quiet_stretch();
    int start;
    start = bytes_sent;
    idle_en = 1'b0;
    while (bytes_sent - start < QUIET_BYTES) send_random_frame(6);
    idle_en = 1'b1;
  endtask

  // mostly well-formed frames, some noise and broken headers
  task automatic test_random_traffic();
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_random_frame(12);
      end else if (pick < 70) begin
        send_random_frame(40);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
      end else if (pick < 97) begin
        send_broken_header();
      end else begin
        wait_for_acks();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_size_wrap();
    test_quiet_stretch();
    test_random_traffic();
    wait_for_acks();
    if (pending_acks.size() != 0) begin
      errors++;
      $display("%0t tb: %0d results never arrived", $time, pending_acks.size());
    end
    $display("tb: %0d bytes in, %0d frames closed, %0d acknowledgements, %0d partner acks",
             bytes_sent, frames_closed, acks_seen, partner_acks_seen);
    $display("tb: covered zero and odd/even lengths, length 255 body count, broken headers");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
